FILE: rtl/lddf_pkg.sv
// Shared types and codes for the list deque engine.
// Used by lddf_seq, list_deque_delete_first_match and the testbench; no dependencies.
package lddf_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned STATUS_W = 2;
    // status, element_value, element_count packed from bit 0 up
    localparam int unsigned M_DATA_W = STATUS_W + VALUE_W + COUNT_W;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_REMOVE     = 3'd4,
        K_READ_OUT   = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } res_t;

endpackage

FILE: rtl/list_deque_delete_first_match.sv
// Push/pop and unused kinds: the result is held in S_RESP, then in the output register.
// Remove: a read and a compare per element compared, a read and a write per element moved up.
// Read out: a read (S_RD_REQ) and an emit (S_RD_EMIT) per element, a stall holding the emit; both loops
// are paced by the store's registered read.
// One item at a time; s_tready is low until the item's last result has left the
// sequencer. A result register lets the next item start while the last one waits.
// Reset (aresetn low, synchronous): list empty, no result pending; store not cleared.
module list_deque_delete_first_match #(
    parameter int unsigned MAX_ELEMENTS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,  // value_in
    input  logic [7:0]                       s_tuser,  // kind, zero fill
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lddf_pkg::M_DATA_W-1:0]    m_tdata,  // status, element_value, element_count
    output logic                             m_tlast
);
    import lddf_pkg::*;

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    logic                 res_valid, res_ready;
    res_t                 res;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [VALUE_W-1:0]   mem_wdata, mem_rdata;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    lddf_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW),
        .CW           (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser[KIND_W-1:0])),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lddf_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: takes a new result whenever the slot is free or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_tdata_next = {res.count, res.value, res.status};
                m_tlast_next = res.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/lddf_mem.sv
// Element store: one write port, one read port with registered read data.
// No package dependency.
module lddf_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lddf_seq.sv
// Sequencer of the list engine: circular-buffer pointers, count, the scan loop with its compare,
// the shift and read-out loops. Uses lddf_pkg; the store sits outside on the mem_* ports.
module lddf_seq #(
    parameter int unsigned MAX_ELEMENTS = 32,
    parameter int unsigned AW           = 5,
    parameter int unsigned CW           = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lddf_pkg::kind_t                 in_kind,
    input  logic [lddf_pkg::VALUE_W-1:0]    in_value,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lddf_pkg::res_t                  res,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [lddf_pkg::VALUE_W-1:0]    mem_wdata,
    output logic                            mem_re,
    output logic [AW-1:0]                   mem_raddr,
    input  logic [lddf_pkg::VALUE_W-1:0]    mem_rdata
);
    import lddf_pkg::*;

    localparam logic [AW:0]   MaxP = (AW+1)'(MAX_ELEMENTS);
    localparam logic [CW-1:0] MaxC = CW'(MAX_ELEMENTS);
    localparam logic [AW-1:0] TopA = AW'(MAX_ELEMENTS - 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_RESP      = 8'b0000_0010,
        S_SCAN_REQ  = 8'b0000_0100,
        S_SCAN_CMP  = 8'b0000_1000,
        S_SHIFT_REQ = 8'b0001_0000,
        S_SHIFT_WR  = 8'b0010_0000,
        S_RD_REQ    = 8'b0100_0000,
        S_RD_EMIT   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    status_t             status_reg, status_next;

    logic full, empty, idx_is_last, shift_done, hit;

    // logical position -> physical slot, ring of MAX_ELEMENTS entries
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, off};
        if (s >= MaxP) begin
            s = s - MaxP;
        end
        return s[AW-1:0];
    endfunction

    assign full        = (count_reg == MaxC);
    assign empty       = (count_reg == '0);
    assign idx_is_last = (CW'(idx_reg) + CW'(1) == count_reg);
    assign shift_done  = (CW'(idx_reg) + CW'(2) == count_reg);
    assign hit         = (mem_rdata == key_reg);   // the scan compare

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP) || (state_reg == S_RD_EMIT);

    always_comb begin
        res.status = (state_reg == S_RD_EMIT) ? ST_OK : status_reg;
        res.value  = (state_reg == S_RD_EMIT) ? mem_rdata : '0;
        res.count  = COUNT_W'(count_reg);
        res.last   = (state_reg == S_RD_EMIT) ? idx_is_last : 1'b1;
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    key_next    = in_value;
                    idx_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    unique case (in_kind)
                        K_PUSH_FRONT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                head_next  = (head_reg == '0) ? TopA : head_reg - AW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = head_next;
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        K_PUSH_BACK: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = phys(head_reg, count_reg[AW-1:0]);
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        K_POP_FRONT: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                head_next  = phys(head_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        K_POP_BACK: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        K_REMOVE: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                state_next = S_SCAN_REQ;
                            end
                        end
                        K_READ_OUT: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                state_next = S_RD_REQ;
                            end
                        end
                        default: begin
                            // unused kinds: no change, plain ok transfer
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_REQ: begin
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, idx_reg);
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    if (idx_is_last) begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SHIFT_REQ;
                    end
                end else if (idx_is_last) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_SCAN_REQ;
                end
            end
            S_SHIFT_REQ: begin
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, idx_reg + AW'(1));
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // close the gap: entry idx takes the one behind it
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                if (shift_done) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_SHIFT_REQ;
                end
            end
            S_RD_REQ: begin
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, idx_reg);
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (res_ready) begin
                    if (idx_is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD_REQ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxC)
        else $error("element count above capacity");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.status == ST_FULL) |-> full)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.status == ST_EMPTY) |-> empty)
        else $error("empty status on a non-empty list");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !res_valid && !mem_re)
        else $error("accepting while an item is in progress");

endmodule

FILE: tb/sv/list_result_checker.sv
// Result checker for the list deque engine: tracks the list contents from the input
// transfers, predicts every result and compares the output transfers against them.
// Depends on lddf_pkg for field widths, kind and status codes and the result struct.
module list_result_checker #(
    parameter int unsigned MAX_ELEMENTS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    input  logic [7:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lddf_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             results_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import lddf_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [VALUE_W-1:0] list_vals[$];
    res_t               due_q[$];
    int                 n_bad;
    int                 n_due;

    assign mismatch_count = n_bad;
    assign results_due    = n_due;

    function automatic void add_due(status_t st, logic [VALUE_W-1:0] val, logic is_last);
        res_t r;
        r.status = st;
        r.value  = val;
        r.count  = COUNT_W'(list_vals.size());
        r.last   = is_last;
        due_q.push_back(r);
    endfunction

    // Apply one operation to the tracked list and queue the results it causes.
    function automatic void apply_list_op(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] val);
        status_t st;
        int      n;
        st = ST_OK;
        n  = list_vals.size();
        case (kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (n >= MAX_ELEMENTS)
                    st = ST_FULL;
                else if (kind == K_PUSH_FRONT)
                    list_vals.push_front(val);
                else
                    list_vals.push_back(val);
            end
            K_POP_FRONT: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_vals.pop_front());
            end
            K_POP_BACK: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_vals.pop_back());
            end
            K_REMOVE: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    st = ST_NOT_FOUND;
                    for (int i = 0; i < n; i++) begin
                        if (list_vals[i] == val) begin
                            list_vals.delete(i);
                            st = ST_OK;
                            break;
                        end
                    end
                end
            end
            K_READ_OUT: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < n; i++)
                        add_due(ST_OK, list_vals[i], i == n - 1);
                    return;
                end
            end
            default: ;  // spare kinds leave the list alone
        endcase
        add_due(st, '0, 1'b1);
    endfunction

    function automatic void report_bad(res_t got, res_t want, logic stray);
        n_bad++;
        if (n_bad <= REPORT_MAX) begin
            if (stray)
                $display("%0t: unexpected result st=%0d val=%h cnt=%0d last=%0b", $realtime,
                         got.status, got.value, got.count, got.last);
            else
                $display({"%0t: mismatch exp st=%0d val=%h cnt=%0d last=%0b, ",
                          "got st=%0d val=%h cnt=%0d last=%0b"},
                         $realtime, want.status, want.value, want.count, want.last,
                         got.status, got.value, got.count, got.last);
        end
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            list_vals.delete();
            due_q.delete();
        end else begin
            // results pass the sequencer state and the output register after their input, so check first
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[STATUS_W-1:0]);
                got.value  = m_tdata[STATUS_W +: VALUE_W];
                got.count  = m_tdata[STATUS_W+VALUE_W +: COUNT_W];
                got.last   = m_tlast;
                if (due_q.size() == 0) begin
                    report_bad(got, got, 1'b1);
                end else begin
                    want = due_q.pop_front();
                    if (got.status != want.status || got.value != want.value ||
                        got.count != want.count || got.last != want.last)
                        report_bad(got, want, 1'b0);
                end
            end
            if (s_tvalid && s_tready)
                apply_list_op(s_tuser[KIND_W-1:0], s_tdata);
        end
        n_due = due_q.size();
    end

endmodule

FILE: tb/sv/tb_list_deque_delete_first_match.sv
// Top of the list deque engine testbench: clock, reset, stimulus and verdict.
// Drives list_deque_delete_first_match and checks it through list_result_checker;
// uses lddf_pkg for the kind codes and field widths.
module tb_list_deque_delete_first_match;
    timeunit 1ns;
    timeprecision 1ps;
    import lddf_pkg::*;

    localparam int unsigned LIST_DEPTH = 32;
    localparam int          N_ITEMS    = 400;
    localparam int          QUIET_TAIL = 60;
    localparam int          END_CYCLES = 150;
    localparam int          STALL_LIMIT = 3000;

    // kinds outside the enum, ignored by the block
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIX } run_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic [7:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    int                   mismatch_count;
    int                   results_due;
    int                   idle_cycles;
    bit                   quiet;

    list_deque_delete_first_match #(.MAX_ELEMENTS(LIST_DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    list_result_checker #(.MAX_ELEMENTS(LIST_DEPTH)) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts and ready stretches; no stalls once quiet.
    initial begin : sink
        int hold;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 19);
            end else begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 40);
            end
            repeat (hold - 1) @(negedge aclk);
        end
    end

    // Small pool so that removes hit and duplicates build up.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            4:       v = 32'h0000_0001;
            5:       v = 32'h5555_5555;
            6:       v = 32'hAAAA_AAAA;
            default: v = 32'h0000_1234;
        endcase
        return v;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(run_mode_t mode);
        int r;
        int push_end;
        int popf_end;
        int popb_end;
        int rem_end;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:   begin push_end = 88; popf_end = 92; popb_end = 95; rem_end = 98; end
            MODE_SHRINK: begin push_end = 13; popf_end = 38; popb_end = 60; rem_end = 88; end
            default:     begin push_end = 40; popf_end = 52; popb_end = 64; rem_end = 84; end
        endcase
        if (r < 3)
            return ($urandom_range(0, 1) == 0) ? KIND_SPARE6 : KIND_SPARE7;
        if (r < push_end)
            return ($urandom_range(0, 1) == 0) ? K_PUSH_FRONT : K_PUSH_BACK;
        if (r < popf_end) return K_POP_FRONT;
        if (r < popb_end) return K_POP_BACK;
        if (r < rem_end)  return K_REMOVE;
        return K_READ_OUT;
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= {{(8 - KIND_W){1'b0}}, kind};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the input side until the last predicted result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
    endtask

    initial begin : stim
        run_mode_t mode;
        int        seg_left;
        int        seg_no;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        quiet       = 1'b0;
        aresetn     = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty-list cases and spare kinds
        send_item(K_READ_OUT,   32'h0);
        send_item(K_POP_FRONT,  32'h0);
        send_item(K_POP_BACK,   32'hFFFF_FFFF);
        send_item(K_REMOVE,     32'h0);
        send_item(KIND_SPARE6,  32'hFFFF_FFFF);
        send_item(KIND_SPARE7,  32'h0);
        // extremes, duplicates, first match removal
        send_item(K_PUSH_FRONT, 32'h8000_0000);
        send_item(K_PUSH_BACK,  32'h7FFF_FFFF);
        send_item(K_PUSH_FRONT, 32'h0000_0000);
        send_item(K_PUSH_BACK,  32'hFFFF_FFFF);
        send_item(K_PUSH_BACK,  32'h8000_0000);
        send_item(K_READ_OUT,   32'h0);
        send_item(K_REMOVE,     32'h1234_5678);
        send_item(K_REMOVE,     32'h8000_0000);
        send_item(K_READ_OUT,   32'h0);
        send_item(KIND_SPARE7,  32'h5555_5555);
        send_item(K_REMOVE,     32'hFFFF_FFFF);
        send_item(K_REMOVE,     32'h8000_0000);
        send_item(K_POP_BACK,   32'h0);
        send_item(K_POP_FRONT,  32'h0);
        send_item(K_READ_OUT,   32'h0);
        send_item(K_REMOVE,     32'h7FFF_FFFF);
        drain_results();

        // first segment grows the list to make full pushes likely
        mode     = MODE_GROW;
        seg_left = 50;
        seg_no   = 0;
        for (int n = 0; n < N_ITEMS - 22; n++) begin
            if (seg_left == 0) begin
                seg_no++;
                seg_left = $urandom_range(15, 50);
                case ($urandom_range(0, 2))
                    0:       mode = MODE_GROW;
                    1:       mode = MODE_SHRINK;
                    default: mode = MODE_MIX;
                endcase
            end
            seg_left--;
            if (n == 200)
                drain_results();
            if (n >= N_ITEMS - 22 - QUIET_TAIL)
                quiet = 1'b1;
            send_item(pick_kind(mode), pick_value());
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (results_due != 0) @(negedge aclk);
        repeat (END_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lddf_pkg.sv
rtl/lddf_mem.sv
rtl/lddf_seq.sv
rtl/list_deque_delete_first_match.sv
tb/sv/list_result_checker.sv
tb/sv/tb_list_deque_delete_first_match.sv
